>>> src/sld_pkg.sv
// shared types, constants and crc helper for the sof/length/crc-32 deframer
`default_nettype none
package sld_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int CRC_W     = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [BYTE_W-1:0] SOF_RESET = 8'd165;
    localparam logic [LEN_W-1:0]  MAX_RESET = 16'd1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOF_BYTE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 8'd1;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_GOOD,
        KIND_BAD_CRC,
        KIND_TOO_LONG
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TYPE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PAYLOAD,
        ST_CRC
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [BYTE_W-1:0]  frame_type;
        logic [LEN_W-1:0]   payload_length;
    } result_t;

    // reflected crc-32, one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> src/sld_in_reg.sv
// input register stage holding one received byte
`default_nettype none
module sld_in_reg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [sld_pkg::BYTE_W-1:0] s_rx_byte,
    input  wire logic                      advance,
    output logic                           in_valid,
    output logic [sld_pkg::BYTE_W-1:0]     in_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [sld_pkg::BYTE_W-1:0] byte_reg;

    assign s_ready  = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule
`default_nettype wire

>>> src/sld_core.sv
// frame state machine, crc datapath and configuration registers
`default_nettype none
module sld_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sld_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire logic                         advance,
    input  wire logic [sld_pkg::BYTE_W-1:0]   in_byte,
    output logic                              res_valid,
    output sld_pkg::result_t                  res
);

    sld_pkg::state_t             state_reg, state_next;
    logic [sld_pkg::BYTE_W-1:0]  sof_reg;
    logic [sld_pkg::LEN_W-1:0]   max_reg;
    logic [sld_pkg::BYTE_W-1:0]  type_reg, type_next;
    logic [sld_pkg::LEN_W-1:0]   length_reg, length_next;
    logic [sld_pkg::LEN_W-1:0]   remain_reg, remain_next;
    logic [1:0]                  crc_idx_reg, crc_idx_next;
    logic [sld_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [23:0]                 rx_crc_reg, rx_crc_next;
    logic [sld_pkg::CRC_W-1:0]   crc_upd;
    logic [sld_pkg::LEN_W-1:0]   len_full;
    logic [sld_pkg::CRC_W-1:0]   rx_crc_full;

    assign crc_upd     = sld_pkg::crc_byte(crc_reg, in_byte);
    assign len_full    = {in_byte, length_reg[7:0]};
    assign rx_crc_full = {in_byte, rx_crc_reg};

    always_comb begin
        state_next   = state_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        remain_next  = remain_reg;
        crc_idx_next = crc_idx_reg;
        crc_next     = crc_reg;
        rx_crc_next  = rx_crc_reg;
        res_valid    = 1'b0;
        res.kind           = sld_pkg::KIND_DATA;
        res.data_byte      = '0;
        res.frame_type     = type_reg;
        res.payload_length = length_reg;
        case (state_reg)
            sld_pkg::ST_IDLE: begin
                if (in_byte == sof_reg) begin
                    state_next = sld_pkg::ST_TYPE;
                    crc_next   = sld_pkg::CRC_INIT;
                end
            end
            sld_pkg::ST_TYPE: begin
                type_next  = in_byte;
                crc_next   = crc_upd;
                state_next = sld_pkg::ST_LEN_LO;
            end
            sld_pkg::ST_LEN_LO: begin
                length_next = {8'h00, in_byte};
                crc_next    = crc_upd;
                state_next  = sld_pkg::ST_LEN_HI;
            end
            sld_pkg::ST_LEN_HI: begin
                length_next  = len_full;
                crc_next     = crc_upd;
                remain_next  = len_full;
                crc_idx_next = 2'd0;
                if (len_full > max_reg) begin
                    // oversized frame ends at once
                    res_valid          = 1'b1;
                    res.kind           = sld_pkg::KIND_TOO_LONG;
                    res.payload_length = len_full;
                    state_next         = sld_pkg::ST_IDLE;
                end else if (len_full == '0) begin
                    state_next = sld_pkg::ST_CRC;
                end else begin
                    state_next = sld_pkg::ST_PAYLOAD;
                end
            end
            sld_pkg::ST_PAYLOAD: begin
                crc_next      = crc_upd;
                remain_next   = remain_reg - 16'd1;
                res_valid     = 1'b1;
                res.kind      = sld_pkg::KIND_DATA;
                res.data_byte = in_byte;
                if (remain_reg == 16'd1) begin
                    state_next   = sld_pkg::ST_CRC;
                    crc_idx_next = 2'd0;
                end
            end
            sld_pkg::ST_CRC: begin
                crc_idx_next = crc_idx_reg + 2'd1;
                case (crc_idx_reg)
                    2'd0:    rx_crc_next[7:0]   = in_byte;
                    2'd1:    rx_crc_next[15:8]  = in_byte;
                    2'd2:    rx_crc_next[23:16] = in_byte;
                    default: begin
                        res_valid  = 1'b1;
                        res.kind   = ((~crc_reg) == rx_crc_full) ? sld_pkg::KIND_GOOD
                                                                 : sld_pkg::KIND_BAD_CRC;
                        state_next = sld_pkg::ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = sld_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sld_pkg::ST_IDLE;
            sof_reg   <= sld_pkg::SOF_RESET;
            max_reg   <= sld_pkg::MAX_RESET;
            type_reg  <= '0;
            length_reg <= '0;
        end else begin
            if (advance) begin
                state_reg  <= state_next;
                type_reg   <= type_next;
                length_reg <= length_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    sld_pkg::REG_SOF_BYTE:    sof_reg <= cfg_data[sld_pkg::BYTE_W-1:0];
                    sld_pkg::REG_MAX_PAYLOAD: max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            remain_reg  <= remain_next;
            crc_idx_reg <= crc_idx_next;
            crc_reg     <= crc_next;
            rx_crc_reg  <= rx_crc_next;
        end
    end

endmodule
`default_nettype wire

>>> src/sld_out_reg.sv
// result register towards the output channel
`default_nettype none
module sld_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic             res_valid,
    input  wire sld_pkg::result_t res,
    output logic                  advance,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sld_pkg::result_t      m_res
);

    logic             valid_reg;
    logic             valid_next;
    logic             out_free;
    sld_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign advance  = in_valid && out_free;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            res_reg <= res;
        end
    end

endmodule
`default_nettype wire

>>> src/sof_length_crc32_deframer.sv
// top level of the start-of-frame / length / crc-32 deframer
// takes one received byte per request; while idle it hunts for the start
// byte, then reads a type byte and a little-endian 16-bit length; a length
// above max_payload ends the frame at once with a length-error verdict;
// payload bytes are passed out one per request as they arrive, then four
// little-endian crc-32 bytes (reflected, poly edb88320, all-ones init and
// final xor over type, length and payload) give a good or bad-crc verdict;
// a new byte is taken every clock cycle unless a held result waits on
// m_ready, sustained rate one byte per cycle, carried by the
// combinational byte-wise crc update and length compare in the core; bytes
// pass the input register, then the result register; configuration writes
// are taken every cycle and must only be made while the block is idle
`default_nettype none
module sof_length_crc32_deframer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // byte input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sld_pkg::BYTE_W-1:0]    s_rx_byte,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_kind,
    output logic [sld_pkg::BYTE_W-1:0]         m_data_byte,
    output logic [sld_pkg::BYTE_W-1:0]         m_frame_type,
    output logic [sld_pkg::LEN_W-1:0]          m_payload_length,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sld_pkg::CFG_DAT_W-1:0] cfg_data
);

    logic                       in_valid;
    logic [sld_pkg::BYTE_W-1:0] in_byte;
    logic                       advance;
    logic                       res_valid;
    sld_pkg::result_t           res;
    sld_pkg::result_t           m_res;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // input register; refills in the same cycle the core consumes it
    sld_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    // frame parsing and crc check
    sld_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register; the core only steps when this slot is free or draining
    sld_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_kind           = m_res.kind;
    assign m_data_byte      = m_res.data_byte;
    assign m_frame_type     = m_res.frame_type;
    assign m_payload_length = m_res.payload_length;

endmodule
`default_nettype wire
